FILE: src/oawd_pkg.sv
`timescale 1ns / 1ps

package oawd_pkg;

  localparam int SENSOR_COUNT_DEF = 8;
  localparam int SENSOR_BITS_DEF  = 12;

  localparam int FORM_W  = 17;
  localparam int SPEED_W = 11;
  localparam int OUT_TDATA_W = 24;

  localparam int THR_W    = 12;
  localparam int LIMIT_W  = 10;
  localparam int OFFSET_W = 9;

  localparam int BRAIT_DIV = 350;
  localparam int DIV_SHIFT = 9;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [2:0] REG_AVOID_THR = 3'd0;
  localparam logic [2:0] REG_FORM_THR  = 3'd1;
  localparam logic [2:0] REG_LIMIT     = 3'd2;
  localparam logic [2:0] REG_LEFT_OFS  = 3'd3;
  localparam logic [2:0] REG_RIGHT_OFS = 3'd4;

  localparam logic [THR_W-1:0]           AVOID_THR_RST = 12'd1800;
  localparam logic [THR_W-1:0]           FORM_THR_RST  = 12'd70;
  localparam logic [LIMIT_W-1:0]         LIMIT_RST     = 10'd800;
  localparam logic signed [OFFSET_W-1:0] LEFT_OFS_RST  = 9'sd66;
  localparam logic signed [OFFSET_W-1:0] RIGHT_OFS_RST = 9'sd72;

  localparam int WEIGHT_R [SENSOR_COUNT_DEF] = '{17, 29, 34, 10, 8, -38, -56, -76};
  localparam int WEIGHT_L [SENSOR_COUNT_DEF] = '{-72, -58, -36, 8, 10, 36, 28, 18};

endpackage

FILE: src/obstacle_avoid_wheel_drive.sv
`timescale 1ns / 1ps
// channel   dir  tdata (lsb up)                                   tuser
// s_*       in   sensor_0..sensor_7, formation_left, formation_right  -
// m_*       out  left_speed, right_speed                           avoiding
// apb       in   avoid_threshold, formation_threshold, speed_limit,
//                left_offset, right_offset at 0x00..0x10
//
// Four register stages: input, weighted sums, reciprocal multiply for the
// divide by 350, then select/rescale/clamp into the output register.
// One word per cycle unless m_tready stalls; valid goes v1, v2, v3 to m_tvalid.
// The mode bit updates as each word enters the output register.
// A stall on m_tready freezes the whole pipe; s_tready = !m_tvalid | m_tready.
// rst is synchronous and clears valids, mode and config registers to their defaults.

module obstacle_avoid_wheel_drive
  import oawd_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int SENSOR_BITS  = SENSOR_BITS_DEF,
  localparam int S_TDATA_W = ((SENSOR_COUNT * SENSOR_BITS + 2 * FORM_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // sensor_0..sensor_7, formation_left, formation_right
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // left_speed, right_speed
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // avoiding
  output logic [0:0]           m_tuser,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int SUM_W  = SENSOR_BITS + 9;
  localparam int MAG_W  = SUM_W - 1;
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam int Q_W    = PROD_W - MAG_W - DIV_SHIFT;
  localparam int RW     = SUM_W + 2;
  localparam int CMP_W  = (SENSOR_BITS > THR_W) ? SENSOR_BITS : THR_W;
  localparam logic [63:0] MAGIC_L =
    ((64'd1 << (MAG_W + DIV_SHIFT)) + 64'(BRAIT_DIV - 1)) / 64'(BRAIT_DIV);
  localparam logic [MAG_W:0] MAGIC = MAGIC_L[MAG_W:0];

  // config registers
  logic [THR_W-1:0]           avoid_thr;
  logic [THR_W-1:0]           form_thr;
  logic [LIMIT_W-1:0]         speed_limit;
  logic signed [OFFSET_W-1:0] left_ofs;
  logic signed [OFFSET_W-1:0] right_ofs;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      avoid_thr   <= AVOID_THR_RST;
      form_thr    <= FORM_THR_RST;
      speed_limit <= LIMIT_RST;
      left_ofs    <= LEFT_OFS_RST;
      right_ofs   <= RIGHT_OFS_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_AVOID_THR: avoid_thr   <= pwdata[THR_W-1:0];
        REG_FORM_THR:  form_thr    <= pwdata[THR_W-1:0];
        REG_LIMIT:     speed_limit <= pwdata[LIMIT_W-1:0];
        REG_LEFT_OFS:  left_ofs    <= $signed(pwdata[OFFSET_W-1:0]);
        REG_RIGHT_OFS: right_ofs   <= $signed(pwdata[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_AVOID_THR: prdata = DATA_W'(avoid_thr);
      REG_FORM_THR:  prdata = DATA_W'(form_thr);
      REG_LIMIT:     prdata = DATA_W'(speed_limit);
      REG_LEFT_OFS:  prdata = DATA_W'(unsigned'(left_ofs));
      REG_RIGHT_OFS: prdata = DATA_W'(unsigned'(right_ofs));
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // stage 1: input register
  logic                          v1;
  logic [SENSOR_BITS-1:0]        sens1 [SENSOR_COUNT];
  logic signed [FORM_W-1:0]      fl1, fr1;

  // stage 2: sums as magnitude and sign, mode flags
  logic                          v2;
  logic [MAG_W-1:0]              mag_l2, mag_r2;
  logic                          neg_l2, neg_r2, enter2, calm2;
  logic signed [FORM_W-1:0]      fl2, fr2;

  // stage 3: quotients
  logic                          v3;
  logic [Q_W-1:0]                q_l3, q_r3;
  logic                          neg_l3, neg_r3, enter3, calm3;
  logic signed [FORM_W-1:0]      fl3, fr3;

  logic                          avoid_mode, mode_next;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        sens1[i] <= s_tdata[i*SENSOR_BITS +: SENSOR_BITS];
      end
      fl1 <= $signed(s_tdata[SENSOR_COUNT*SENSOR_BITS +: FORM_W]);
      fr1 <= $signed(s_tdata[SENSOR_COUNT*SENSOR_BITS + FORM_W +: FORM_W]);
    end
  end

  logic signed [SUM_W-1:0] sum_l, sum_r;
  logic                    enter, calm;

  always_comb begin
    sum_l = '0;
    sum_r = '0;
    calm  = 1'b1;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      sum_r = sum_r + SUM_W'(WEIGHT_R[i]) * SUM_W'($signed({1'b0, sens1[i]}));
      sum_l = sum_l + SUM_W'(WEIGHT_L[i]) * SUM_W'($signed({1'b0, sens1[i]}));
      if (CMP_W'(sens1[i]) >= CMP_W'(form_thr)) begin
        calm = 1'b0;
      end
    end
    enter = (CMP_W'(sens1[0]) > CMP_W'(avoid_thr)) ||
            (CMP_W'(sens1[1]) > CMP_W'(avoid_thr)) ||
            (CMP_W'(sens1[6]) > CMP_W'(avoid_thr)) ||
            (CMP_W'(sens1[7]) > CMP_W'(avoid_thr));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg_l2 <= sum_l[SUM_W-1];
      neg_r2 <= sum_r[SUM_W-1];
      mag_l2 <= sum_l[SUM_W-1] ? MAG_W'(-sum_l) : MAG_W'(sum_l);
      mag_r2 <= sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
      enter2 <= enter;
      calm2  <= calm;
      fl2    <= fl1;
      fr2    <= fr1;
    end
  end

  // divide by 350: multiply by rounded-up reciprocal, exact for MAG_W bits
  logic [PROD_W-1:0] prod_l, prod_r;
  assign prod_l = PROD_W'(mag_l2) * PROD_W'(MAGIC);
  assign prod_r = PROD_W'(mag_r2) * PROD_W'(MAGIC);

  always_ff @(posedge clk) begin
    if (advance) begin
      q_l3   <= prod_l[PROD_W-1 -: Q_W];
      q_r3   <= prod_r[PROD_W-1 -: Q_W];
      neg_l3 <= neg_l2;
      neg_r3 <= neg_r2;
      enter3 <= enter2;
      calm3  <= calm2;
      fl3    <= fl2;
      fr3    <= fr2;
    end
  end

  function automatic void rescale(inout logic signed [RW-1:0] x,
                                  inout logic signed [RW-1:0] y,
                                  input logic signed [RW-1:0] lim);
    logic signed [RW-1:0] d;
    d = '0;
    if (x > 0 && y > 0) begin
      if (x > y) begin
        d = x - y;
        if (x > lim) begin x = lim; y = lim - d; end
      end else begin
        d = y - x;
        if (y > lim) begin y = lim; x = lim - d; end
      end
    end else if (x > 0 && y < 0) begin
      d = x - y;
      if (x >= lim && y <= -lim) begin x = lim; y = -lim; end
      else if (x >= lim) begin x = lim; y = lim - d; end
      else if (y <= -lim) begin x = -lim + d; y = -lim; end
    end else if (x < 0 && y > 0) begin
      d = y - x;
      if (x <= -lim && y >= lim) begin x = -lim; y = lim; end
      else if (y >= lim) begin x = lim - d; y = lim; end
      else if (x <= -lim) begin x = -lim; y = -lim + d; end
    end else if (x < 0 && y < 0) begin
      if (x < y) begin
        d = y - x;
        if (x < -lim) begin x = -lim; y = -lim + d; end
      end else begin
        d = x - y;
        if (y < -lim) begin x = -lim + d; y = -lim; end
      end
    end
  endfunction

  logic                 mode_sel;
  logic signed [RW-1:0] qx_l, qx_r, br_l, br_r, lim, wx, wy;
  logic signed [RW-1:0] cl_l, cl_r;

  always_comb begin
    mode_sel  = avoid_mode || enter3;
    mode_next = mode_sel && !calm3;
    qx_l = $signed(RW'(q_l3));
    qx_r = $signed(RW'(q_r3));
    br_l = (neg_l3 ? -qx_l : qx_l) + RW'(left_ofs);
    br_r = (neg_r3 ? -qx_r : qx_r) + RW'(right_ofs);
    lim  = $signed(RW'(speed_limit));
    wx   = mode_sel ? br_l : RW'(fl3);
    wy   = mode_sel ? br_r : RW'(fr3);
    rescale(wx, wy, lim);
    cl_l = (wx > lim) ? lim : ((wx < -lim) ? -lim : wx);
    cl_r = (wy > lim) ? lim : ((wy < -lim) ? -lim : wy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      m_tvalid   <= 1'b0;
      avoid_mode <= 1'b0;
    end else if (advance) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
      if (v3) begin
        avoid_mode <= mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OUT_TDATA_W - 2 * SPEED_W){1'b0}},
                  SPEED_W'(cl_r), SPEED_W'(cl_l)};
      m_tuser <= mode_next;
    end
  end

endmodule

FILE: src/oawd_checker.sv
`timescale 1ns / 1ps

module oawd_checker
  import oawd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [0:0]             m_tuser,
  input logic                   pready
);

  // output register empties on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid set after reset");

  // held word stays put under backpressure
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // input side takes a word whenever the output register can move
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output register");

  // speeds stay within +/-1023 and padding bits stay zero
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:0] != 11'h400 && m_tdata[21:11] != 11'h400 &&
                 m_tdata[OUT_TDATA_W-1:22] == '0)
    else $error("wheel speed out of range");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind obstacle_avoid_wheel_drive oawd_checker u_oawd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
